/* src/pft_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pft_pkg;

    // Width of the number, factor and totient fields on the ports
    localparam int DATA_W = 32;

    // Default width of the number that is actually factored
    localparam int NUM_BITS_DEF = 32;

    // First odd trial divisor
    localparam int FIRST_ODD = 3;

    typedef enum logic [5:0]
    {
        ST_IDLE  = 6'b000001,
        ST_TWO   = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_EVAL  = 6'b001000,
        ST_TAIL  = 6'b010000,
        ST_FINAL = 6'b100000
    } state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* src/prime_factor_totient_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = number
// m_*       out  m_tvalid/m_tready  m_tdata = factor, totient; m_tlast = last;
//                                   m_tuser = no_factors
//
// One number at a time; s_tready is high only while the sequencer is idle.
// Factors of two are stripped by a shift, without the divider. Every odd trial
// divisor and every totient update runs one pass of the shared restoring
// divider, so a 32-bit prime needs roughly 32768 passes. Reset is asynchronous
// and needs no clearing pass. A stalled m_tready holds the sequencer whenever a
// factor must move to the output.

module prime_factor_totient_unit
#(
    parameter int NUM_BITS = pft_pkg::NUM_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] number
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // [31:0] factor, [63:32] totient
    output logic             m_tlast,
    output logic             m_tuser    // [0] no_factors
);

    localparam int OW = pft_pkg::DATA_W;
    localparam int VW = (NUM_BITS < OW) ? NUM_BITS : OW;
    localparam int DW = (VW + 1) / 2 + 1;

    pft_pkg::state_t    state_reg, state_next;

    logic [VW-1:0] rem_val_reg, rem_val_next;
    logic [DW-1:0] div_reg, div_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic          counted_reg, counted_next;
    logic          outer_reg, outer_next;
    logic          tot_reg, tot_next;
    logic          tail_reg, tail_next;
    logic          nofac_reg, nofac_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [VW-1:0] pend_factor_reg, pend_factor_next;

    logic          div_start_reg, div_start_next;
    logic [VW-1:0] div_a_reg, div_a_next;
    logic [VW-1:0] div_b_reg, div_b_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [VW-1:0] m_factor_reg, m_factor_next;
    logic [VW-1:0] m_tot_reg, m_tot_next;
    logic          m_last_reg, m_last_next;
    logic          m_nofac_reg, m_nofac_next;

    pft_pkg::div_stat_t div_stat;
    logic [VW-1:0] quo;
    logic [VW-1:0] rmd;

    logic          out_free;
    logic          can_record;
    logic          rec_en;
    logic [VW-1:0] rec_p;
    logic          final_en;
    logic [VW-1:0] in_val;
    logic [VW-1:0] d_ext;
    logic [DW-1:0] div_plus2;

    pft_divider #(
        .WIDTH (VW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_a_reg),
        .divisor   (div_b_reg),
        .stat      (div_stat),
        .quotient  (quo),
        .remainder (rmd)
    );

    assign out_free   = !m_tvalid_reg || m_tready;
    assign can_record = !pend_valid_reg || out_free;
    assign in_val     = s_tdata[VW-1:0];
    assign d_ext      = VW'(div_reg);
    assign div_plus2  = div_reg + DW'(2);

    always_comb
    begin
        state_next       = state_reg;
        rem_val_next     = rem_val_reg;
        div_next         = div_reg;
        acc_next         = acc_reg;
        counted_next     = counted_reg;
        outer_next       = outer_reg;
        tot_next         = tot_reg;
        tail_next        = tail_reg;
        nofac_next       = nofac_reg;
        pend_valid_next  = pend_valid_reg;
        pend_factor_next = pend_factor_reg;
        div_start_next   = 1'b0;
        div_a_next       = div_a_reg;
        div_b_next       = div_b_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_factor_next    = m_factor_reg;
        m_tot_next       = m_tot_reg;
        m_last_next      = m_last_reg;
        m_nofac_next     = m_nofac_reg;
        rec_en           = 1'b0;
        rec_p            = '0;
        final_en         = 1'b0;

        case (state_reg)
            pft_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rem_val_next     = in_val;
                    acc_next         = in_val;
                    counted_next     = 1'b0;
                    tail_next        = 1'b0;
                    pend_valid_next  = 1'b0;
                    pend_factor_next = '0;
                    if (in_val < VW'(2))
                    begin
                        nofac_next = 1'b1;
                        state_next = pft_pkg::ST_FINAL;
                    end
                    else
                    begin
                        nofac_next = 1'b0;
                        state_next = pft_pkg::ST_TWO;
                    end
                end
            end

            pft_pkg::ST_TWO:
            begin
                if (!rem_val_reg[0])
                begin
                    if (can_record)
                    begin
                        rec_en       = 1'b1;
                        rec_p        = VW'(2);
                        rem_val_next = rem_val_reg >> 1;
                        if (!counted_reg)
                        begin
                            acc_next     = acc_reg - (acc_reg >> 1);
                            counted_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    div_next       = DW'(pft_pkg::FIRST_ODD);
                    counted_next   = 1'b0;
                    outer_next     = 1'b1;
                    tot_next       = 1'b0;
                    div_start_next = 1'b1;
                    div_a_next     = rem_val_reg;
                    div_b_next     = VW'(pft_pkg::FIRST_ODD);
                    state_next     = pft_pkg::ST_DIV;
                end
            end

            pft_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = pft_pkg::ST_EVAL;
                end
            end

            pft_pkg::ST_EVAL:
            begin
                if (tot_reg)
                begin
                    acc_next     = acc_reg - quo;
                    counted_next = 1'b1;
                    if (tail_reg)
                    begin
                        state_next = pft_pkg::ST_FINAL;
                    end
                    else
                    begin
                        tot_next       = 1'b0;
                        outer_next     = 1'b0;
                        div_start_next = 1'b1;
                        div_a_next     = rem_val_reg;
                        div_b_next     = d_ext;
                        state_next     = pft_pkg::ST_DIV;
                    end
                end
                else if (outer_reg && (quo < d_ext))
                begin
                    state_next = pft_pkg::ST_TAIL;
                end
                else if (rmd == '0)
                begin
                    if (can_record)
                    begin
                        rec_en         = 1'b1;
                        rec_p          = d_ext;
                        rem_val_next   = quo;
                        outer_next     = 1'b0;
                        div_start_next = 1'b1;
                        div_b_next     = d_ext;
                        state_next     = pft_pkg::ST_DIV;
                        if (!counted_reg)
                        begin
                            tot_next   = 1'b1;
                            div_a_next = acc_reg;
                        end
                        else
                        begin
                            div_a_next = quo;
                        end
                    end
                end
                else
                begin
                    div_next       = div_plus2;
                    counted_next   = 1'b0;
                    outer_next     = 1'b1;
                    div_start_next = 1'b1;
                    div_a_next     = rem_val_reg;
                    div_b_next     = VW'(div_plus2);
                    state_next     = pft_pkg::ST_DIV;
                end
            end

            pft_pkg::ST_TAIL:
            begin
                if (rem_val_reg > VW'(1))
                begin
                    if (can_record)
                    begin
                        // leftover quotient is prime; apply it to the totient
                        rec_en         = 1'b1;
                        rec_p          = rem_val_reg;
                        rem_val_next   = VW'(1);
                        counted_next   = 1'b0;
                        tot_next       = 1'b1;
                        tail_next      = 1'b1;
                        div_start_next = 1'b1;
                        div_a_next     = acc_reg;
                        div_b_next     = rem_val_reg;
                        state_next     = pft_pkg::ST_DIV;
                    end
                end
                else
                begin
                    state_next = pft_pkg::ST_FINAL;
                end
            end

            pft_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    final_en   = 1'b1;
                    state_next = pft_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pft_pkg::ST_IDLE;
            end
        endcase

        // Keep the newest factor back so the final one can carry the totient
        if (rec_en)
        begin
            if (pend_valid_reg)
            begin
                m_tvalid_next = 1'b1;
                m_factor_next = pend_factor_reg;
                m_tot_next    = '0;
                m_last_next   = 1'b0;
                m_nofac_next  = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_factor_next = rec_p;
        end

        if (final_en)
        begin
            m_tvalid_next   = 1'b1;
            m_factor_next   = pend_factor_reg;
            m_tot_next      = acc_reg;
            m_last_next     = 1'b1;
            m_nofac_next    = nofac_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pft_pkg::ST_IDLE;
            counted_reg    <= 1'b0;
            outer_reg      <= 1'b0;
            tot_reg        <= 1'b0;
            tail_reg       <= 1'b0;
            nofac_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            counted_reg    <= counted_next;
            outer_reg      <= outer_next;
            tot_reg        <= tot_next;
            tail_reg       <= tail_next;
            nofac_reg      <= nofac_next;
            pend_valid_reg <= pend_valid_next;
            div_start_reg  <= div_start_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_val_reg     <= rem_val_next;
        div_reg         <= div_next;
        acc_reg         <= acc_next;
        pend_factor_reg <= pend_factor_next;
        div_a_reg       <= div_a_next;
        div_b_reg       <= div_b_next;
        m_factor_reg    <= m_factor_next;
        m_tot_reg       <= m_tot_next;
        m_last_reg      <= m_last_next;
        m_nofac_reg     <= m_nofac_next;
    end

    assign s_tready = (state_reg == pft_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {OW'(m_tot_reg), OW'(m_factor_reg)};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_nofac_reg;

    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start_reg |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !pend_valid_reg)
        else $error("input accepted with a factor still held back");

    a_nonfinal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[63:32] == '0) && !m_tuser)
        else $error("non-final result carries totient or no-factor flag");

    a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pft_pkg::ST_EVAL && !tot_reg) |-> div_reg[0])
        else $error("trial divisor is even in the odd phase");

    a_final_has_factor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pft_pkg::ST_FINAL && !nofac_reg) |-> pend_valid_reg)
        else $error("final result without a factor");

endmodule

`default_nettype wire

/* src/pft_divider.sv */
`timescale 1ns / 1ps
`default_nettype none

module pft_divider
#(
    parameter int WIDTH = pft_pkg::NUM_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [WIDTH-1:0]   dividend,
    input  wire logic [WIDTH-1:0]   divisor,
    output pft_pkg::div_stat_t      stat,
    output logic      [WIDTH-1:0]   quotient,
    output logic      [WIDTH-1:0]   remainder
);

    localparam int CW = $clog2(WIDTH);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    // One quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* sim/prime_factor_totient_unit_tb.sv */
`timescale 1ns / 1ps

module prime_factor_totient_unit_tb;

    // A 32-bit prime produces no transaction for its whole trial division; the limit must cover that.
    localparam int WATCHDOG_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS   = 100;
    localparam int DIR_ROWS       = 18;
    localparam int DRAIN_CYCLES   = 64;
    localparam int MAX_GAP        = 12;

    typedef struct packed
    {
        logic [pft_pkg::DATA_W-1:0] factor;
        logic                       last;
        logic                       no_factors;
        logic [pft_pkg::DATA_W-1:0] totient;
    } factor_result_t;

    typedef struct packed
    {
        logic [pft_pkg::DATA_W-1:0] number;
        logic                       typed;
        factor_result_t             result;
    } directed_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    factor_result_t factor_q[$];
    directed_row_t  directed_tbl[DIR_ROWS];
    int             error_count = 0;
    int             idle_cycles = 0;
    bit             steady      = 1'b0;

    prime_factor_totient_unit #(
        .NUM_BITS (pft_pkg::NUM_BITS_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Append one expected transaction at the tail of the queue.
    function automatic void add_expected(input factor_result_t r);
        factor_q.insert(factor_q.size(), r);
    endfunction

    // Trial division with the totient folded in once per distinct prime.
    function automatic void predict_factorization(input logic [pft_pkg::DATA_W-1:0] num);
        logic [63:0]    rem;
        logic [63:0]    tot;
        logic [63:0]    d;
        logic [63:0]    primes[$];
        factor_result_t r;
        if (num < 2)
        begin
            r.factor     = '0;
            r.last       = 1'b1;
            r.no_factors = 1'b1;
            r.totient    = num;
            add_expected(r);
            return;
        end
        rem = 64'(num);
        tot = 64'(num);
        if (rem[0] == 1'b0)
            tot = tot - tot / 2;
        while (rem[0] == 1'b0)
        begin
            primes.insert(primes.size(), 64'd2);
            rem = rem >> 1;
        end
        d = 64'(pft_pkg::FIRST_ODD);
        while (d <= rem / d)
        begin
            if (rem % d == 0)
                tot = tot - tot / d;
            while (rem % d == 0)
            begin
                primes.insert(primes.size(), d);
                rem = rem / d;
            end
            d = (d + 64'd2) & 64'h1FFFF;
        end
        // leftover quotient is prime
        if (rem > 1)
        begin
            tot = tot - tot / rem;
            primes.insert(primes.size(), rem);
        end
        foreach (primes[i])
        begin
            r.factor     = primes[i][pft_pkg::DATA_W-1:0];
            r.last       = (i == primes.size() - 1);
            r.no_factors = 1'b0;
            r.totient    = r.last ? tot[pft_pkg::DATA_W-1:0] : '0;
            add_expected(r);
        end
    endfunction

    // Mostly products of small factors so trial division stays short.
    function automatic logic [pft_pkg::DATA_W-1:0] random_number();
        int          kind;
        logic [63:0] v;
        logic [63:0] f;
        bit          big_used;
        kind     = $urandom_range(0, 9);
        big_used = 1'b0;
        v        = 64'd1;
        case (kind)
            0: v = $urandom_range(0, 1) ? 64'($urandom_range(0, 3))
                                        : (64'd1 << $urandom_range(0, 31));
            1: v = 64'($urandom_range(0, 1 << 20));
            default:
            begin
                repeat ($urandom_range(1, 12))
                begin
                    if (!big_used && $urandom_range(0, 3) == 0)
                    begin
                        f        = 64'($urandom_range(2, 65535));
                        big_used = 1'b1;
                    end
                    else
                        f = 64'($urandom_range(2, 300));
                    if (v * f <= 64'hFFFF_FFFF)
                        v = v * f;
                end
            end
        endcase
        return v[pft_pkg::DATA_W-1:0];
    endfunction

    task automatic send_number(input logic [pft_pkg::DATA_W-1:0] num);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= num;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Result side: random stalls, compare each transaction with the oldest expectation.
    initial
    begin
        int             gap;
        factor_result_t got;
        factor_result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got.factor     = m_tdata[31:0];
            got.totient    = m_tdata[63:32];
            got.last       = m_tlast;
            got.no_factors = m_tuser;
            if (factor_q.size() == 0)
            begin
                $error("unexpected result: factor %0d totient %0d", got.factor, got.totient);
                error_count++;
            end
            else
            begin
                want = factor_q.pop_front();
                if (got.factor !== want.factor)
                begin
                    $error("factor: expected %0d, got %0d", want.factor, got.factor);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    error_count++;
                end
                if (got.no_factors !== want.no_factors)
                begin
                    $error("no_factors: expected %0d, got %0d", want.no_factors,
                           got.no_factors);
                    error_count++;
                end
                if (got.totient !== want.totient)
                begin
                    $error("totient: expected %0d, got %0d", want.totient, got.totient);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [pft_pkg::DATA_W-1:0] num;
        directed_tbl = '{
            '{32'd0,          1'b1, '{32'd0,          1'b1, 1'b1, 32'd0}},
            '{32'd1,          1'b1, '{32'd0,          1'b1, 1'b1, 32'd1}},
            '{32'd2,          1'b1, '{32'd2,          1'b1, 1'b0, 32'd1}},
            '{32'd3,          1'b1, '{32'd3,          1'b1, 1'b0, 32'd2}},
            '{32'd4,          1'b0, '0},
            '{32'd6,          1'b0, '0},
            '{32'd9,          1'b0, '0},
            '{32'd49,         1'b0, '0},
            '{32'd30030,      1'b0, '0},
            '{32'd65537,      1'b1, '{32'd65537,      1'b1, 1'b0, 32'd65536}},
            '{32'd131042,     1'b0, '0},
            '{32'd3486784401, 1'b0, '0},
            '{32'h8000_0000,  1'b0, '0},
            '{32'hFFFF_FFFF,  1'b0, '0},
            '{32'hFFFF_FFFE,  1'b0, '0},
            '{32'h5555_5555,  1'b0, '0},
            '{32'hAAAA_AAAA,  1'b0, '0},
            '{32'd4294967291, 1'b1, '{32'd4294967291, 1'b1, 1'b0, 32'd4294967290}}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tbl[i])
        begin
            send_number(directed_tbl[i].number);
            if (directed_tbl[i].typed)
                add_expected(directed_tbl[i].result);
            else
                predict_factorization(directed_tbl[i].number);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // switch between stretches with and without idling
            if (i % 16 == 0)
                steady = ($urandom_range(0, 2) == 0);
            num = random_number();
            send_number(num);
            predict_factorization(num);
        end
        s_tvalid <= 1'b0;

        while (factor_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/pft_pkg.sv
src/pft_divider.sv
src/prime_factor_totient_unit.sv
sim/prime_factor_totient_unit_tb.sv
